[hw/rtl/swm_pkg.sv]
// swm_pkg: shared types, constants and the letter code table for the soundex word matcher
// no dependencies; every other file of the block imports it

package swm_pkg;

    localparam int TEXT_W        = 8;
    localparam int LETTER_W      = 7;
    localparam int DIGIT_W       = 3;
    localparam int NUM_DIGITS    = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LETTER      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DIGIT_ONE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DIGIT_TWO   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DIGIT_THREE = 2'd3;

    localparam logic [DIGIT_W-1:0] CODE_NONE = 3'd0;

    typedef enum logic [1:0] {
        TOK_SKIP,
        TOK_LETTER,
        TOK_SPACE
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t             kind;
        logic [LETTER_W-1:0]   letter;   // upper-case letter
        logic [DIGIT_W-1:0]    code;     // soundex code of the letter
        logic                  last;     // last byte of the header
    } token_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [DIGIT_W-1:0]  digit_one;
        logic [DIGIT_W-1:0]  digit_two;
        logic [DIGIT_W-1:0]  digit_three;
    } target_t;

    // soundex code by letter position, A is 1 and Z is 26
    function automatic logic [DIGIT_W-1:0] letter_code(input logic [4:0] pos);
        logic [DIGIT_W-1:0] code;
        case (pos)
            5'd2, 5'd6, 5'd16, 5'd22:                          code = 3'd1;
            5'd3, 5'd7, 5'd10, 5'd11, 5'd17, 5'd19, 5'd24, 5'd26: code = 3'd2;
            5'd4, 5'd20:                                       code = 3'd3;
            5'd12:                                             code = 3'd4;
            5'd13, 5'd14:                                      code = 3'd5;
            5'd18:                                             code = 3'd6;
            default:                                           code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/swm_if.sv]
// swm_if: valid/ready channel interfaces for text bytes and match results
// depends on swm_pkg for field widths

interface swm_in_if
    import swm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TEXT_W-1:0]   text_byte;
    logic                final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface swm_out_if
    import swm_pkg::*;
();
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

[hw/rtl/swm_front.sv]
// swm_front: accepts text beats and turns each byte into a token for the queue
// depends on swm_pkg and swm_in_if

module swm_front
    import swm_pkg::*;
(
    swm_in_if.sink      text_ch,
    output logic        push_valid,
    output token_t      push_tok,
    input  logic        push_ready
);

    logic [TEXT_W-1:0]   b;
    logic [LETTER_W-1:0] upper;
    tok_kind_t           kind;

    assign b     = text_ch.text_byte;
    // clearing bit 5 folds lower case onto upper case
    assign upper = b[LETTER_W-1:0] & ~7'h20;

    always_comb
    begin
        case (b) inside
            8'h20, [8'h09:8'h0D]:        kind = TOK_SPACE;
            [8'h41:8'h5A], [8'h61:8'h7A]: kind = TOK_LETTER;
            default:                     kind = TOK_SKIP;
        endcase
    end

    assign push_tok.kind   = kind;
    assign push_tok.letter = upper;
    assign push_tok.code   = letter_code(upper[4:0]);
    assign push_tok.last   = text_ch.final_byte;

    // ignored bytes that do not close the header never enter the queue
    assign push_valid    = text_ch.valid && (kind != TOK_SKIP || text_ch.final_byte);
    assign text_ch.ready = push_ready;

endmodule

[hw/rtl/swm_queue.sv]
// swm_queue: small token fifo between front and back
// depends on swm_pkg for token_t

module swm_queue
    import swm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  token_t push_tok,
    output logic   push_ready,
    output logic   pop_valid,
    output token_t pop_tok,
    input  logic   pop_ready
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

    token_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != COUNT_MAX);
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[hw/rtl/swm_back.sv]
// swm_back: builds each word's soundex code, compares with the target, holds the result beat
// depends on swm_pkg and swm_out_if

module swm_back
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  target_t    target,
    input  logic       tok_valid,
    input  token_t     tok,
    output logic       tok_ready,
    swm_out_if.source  result_ch
);

    logic [LETTER_W-1:0] word_letter_reg, word_letter_next;
    logic                word_started_reg, word_started_next;
    logic [DIGIT_W-1:0]  word_digits_reg [NUM_DIGITS];
    logic [DIGIT_W-1:0]  word_digits_next [NUM_DIGITS];
    logic [1:0]          digit_count_reg, digit_count_next;
    logic [DIGIT_W-1:0]  previous_code_reg, previous_code_next;
    logic                match_seen_reg, match_seen_next;
    logic                out_valid_reg, out_valid_next;
    logic                matched_reg, matched_next;
    logic                tok_fire;
    logic                hit;

    // a last token needs the result register free or draining this cycle
    assign tok_ready = !tok.last || !out_valid_reg || result_ch.ready;
    assign tok_fire  = tok_valid && tok_ready;

    always_comb
    begin
        word_letter_next   = word_letter_reg;
        word_started_next  = word_started_reg;
        word_digits_next   = word_digits_reg;
        digit_count_next   = digit_count_reg;
        previous_code_next = previous_code_reg;
        match_seen_next    = match_seen_reg;
        out_valid_next     = out_valid_reg && !result_ch.ready;
        matched_next       = matched_reg;
        hit                = 1'b0;

        if (tok_fire)
        begin
            if (tok.kind == TOK_LETTER)
            begin
                if (!word_started_reg)
                begin
                    // first letter is kept as the word letter and only primes duplicate suppression
                    word_started_next  = 1'b1;
                    word_letter_next   = tok.letter;
                    previous_code_next = tok.code;
                end
                else if (tok.code != CODE_NONE)
                begin
                    if (tok.code != previous_code_reg && digit_count_reg != 2'd3)
                    begin
                        word_digits_next[digit_count_reg] = tok.code;
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                    previous_code_next = tok.code;
                end
            end

            if (tok.kind == TOK_SPACE || tok.last)
            begin
                hit = word_started_next && (target.letter != '0)
                    && (word_letter_next == target.letter)
                    && (word_digits_next[0] == target.digit_one)
                    && (word_digits_next[1] == target.digit_two)
                    && (word_digits_next[2] == target.digit_three);
                match_seen_next    = match_seen_reg || hit;
                word_letter_next   = '0;
                word_started_next  = 1'b0;
                word_digits_next   = '{default: '0};
                digit_count_next   = '0;
                previous_code_next = CODE_NONE;
            end

            if (tok.last)
            begin
                out_valid_next  = 1'b1;
                matched_next    = match_seen_next;
                match_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_letter_reg   <= '0;
            word_started_reg  <= 1'b0;
            word_digits_reg   <= '{default: '0};
            digit_count_reg   <= '0;
            previous_code_reg <= CODE_NONE;
            match_seen_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            word_letter_reg   <= word_letter_next;
            word_started_reg  <= word_started_next;
            word_digits_reg   <= word_digits_next;
            digit_count_reg   <= digit_count_next;
            previous_code_reg <= previous_code_next;
            match_seen_reg    <= match_seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.matched = matched_reg;

endmodule

[hw/rtl/soundex_word_matcher_core.sv]
// soundex_word_matcher_core: top level of the soundex word matcher
// depends on swm_pkg, swm_if, swm_front, swm_queue and swm_back
//
// usage
// - text_ch carries one header byte per beat with final_byte set on the last byte;
//   whitespace and the last byte close a word, other non-letters are skipped
// - each closed word gets a four-character soundex code that is compared with
//   the target code held in the four configuration registers
// - result_ch carries one beat per header, on its last byte: matched is 1 if
//   any word of the header hit the target
// - configuration: write_enable, write_index, write_data; write only while idle
// - throughput: one byte per cycle while the queue has room, set by the back end taking one token a cycle
//   unless a last token waits for the result register; result path: the last byte's token is written into the
//   queue, then the back end registers the result beat; tokens queued ahead of it are taken first
// - receiver stall: the result sits in the output register; the back end keeps
//   working until the next header's last byte reaches it, then the queue of
//   QUEUE_DEPTH tokens fills and text_ch.ready drops
// - reset: clears targets to zero (never match), word state, match memory and queue

module soundex_word_matcher_core
    import swm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    swm_in_if.sink                 text_ch,
    swm_out_if.source              result_ch,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data
);

    target_t target_reg, target_next;

    // tokens from front to queue
    logic   push_valid;
    token_t push_tok;
    logic   push_ready;

    // tokens from queue to back
    logic   pop_valid;
    token_t pop_tok;
    logic   pop_ready;

    // target code registers
    always_comb
    begin
        target_next = target_reg;
        if (write_enable)
        begin
            case (write_index)
                REG_TARGET_LETTER:      target_next.letter      = write_data;
                REG_TARGET_DIGIT_ONE:   target_next.digit_one   = write_data[DIGIT_W-1:0];
                REG_TARGET_DIGIT_TWO:   target_next.digit_two   = write_data[DIGIT_W-1:0];
                REG_TARGET_DIGIT_THREE: target_next.digit_three = write_data[DIGIT_W-1:0];
                default:                target_next = target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    // front: byte classification and case folding
    swm_front u_front (
        .text_ch    (text_ch),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    // decoupling queue, lets the front keep taking bytes while the result waits
    swm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_tok    (pop_tok),
        .pop_ready  (pop_ready)
    );

    // back: word code build, compare and result register
    swm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target_reg),
        .tok_valid (pop_valid),
        .tok       (pop_tok),
        .tok_ready (pop_ready),
        .result_ch (result_ch)
    );

endmodule
